// ===== design/xbm_hex_to_pbm_bytes_top_assert.svh =====
// ----------------------------------------------------------------------------
// XBM to PBM byte converter: assertion macros
// Clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef XBM_HEX_TO_PBM_BYTES_TOP_ASSERT_SVH
`define XBM_HEX_TO_PBM_BYTES_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define XBM2PBM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define XBM2PBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/xbm2pbm_pkg.sv =====
// ----------------------------------------------------------------------------
// XBM to PBM byte converter: shared package
// Character codes, register indexes, command types and small helpers.
// ----------------------------------------------------------------------------
package xbm2pbm_pkg;

  localparam int unsigned MAX_DIM_DEF   = 4096;
  localparam int unsigned FIELD_DIM_W   = 12;
  localparam int unsigned FIELD_DIM_MAX = (1 << FIELD_DIM_W) - 1;
  localparam int unsigned VALUE_W       = 16;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [3:0] HEX_TEN    = 4'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_SHORT_WORDS  = 2'd2
  } reg_idx_e;

  typedef enum logic {
    REQ_CHAR = 1'b0,
    REQ_PAD  = 1'b1
  } req_e;

  typedef enum logic {
    CMD_VALUE = 1'b0,
    CMD_ZERO  = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [VALUE_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

  typedef struct packed {
    logic image_done;
    logic high_pending;
  } back_stat_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] nibble;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t r;
    r = '0;
    if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
      r.is_hex = 1'b1;
      r.nibble = 4'(c - CH_DIGIT_0);
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      r.is_hex = 1'b1;
      r.nibble = HEX_TEN + 4'(c - CH_UPPER_A);
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      r.is_hex = 1'b1;
      r.nibble = HEX_TEN + 4'(c - CH_LOWER_A);
    end
    return r;
  endfunction

  function automatic logic [7:0] flip8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = b[i];
    end
    return r;
  endfunction

endpackage

// ===== design/xbm2pbm_in_if.sv =====
// ----------------------------------------------------------------------------
// XBM to PBM byte converter: character channel
// One body character or pad request per word.
// ----------------------------------------------------------------------------
interface xbm2pbm_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] char_code;

  modport source (output valid, output req_type, output char_code, input ready);
  modport sink (input valid, input req_type, input char_code, output ready);
endinterface

// ===== design/xbm2pbm_out_if.sv =====
// ----------------------------------------------------------------------------
// XBM to PBM byte converter: pixel byte channel
// One PBM raw byte with row and image end marks per word.
// ----------------------------------------------------------------------------
interface xbm2pbm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       last_in_row;
  logic       last_in_image;

  modport source (output valid, output pixel_byte, output last_in_row,
                  output last_in_image, input ready);
  modport sink (input valid, input pixel_byte, input last_in_row,
                input last_in_image, output ready);
endinterface

// ===== design/xbm2pbm_cfg_if.sv =====
// ----------------------------------------------------------------------------
// XBM to PBM byte converter: configuration write channel
// Register index and write data per word.
// ----------------------------------------------------------------------------
interface xbm2pbm_cfg_if;
  import xbm2pbm_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [FIELD_DIM_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/xbm2pbm_front.sv =====
// ----------------------------------------------------------------------------
// XBM to PBM byte converter: front end
// Scans characters for hex values and queues one command per value or pad.
// ----------------------------------------------------------------------------
module xbm2pbm_front
  import xbm2pbm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  xbm2pbm_in_if.sink          char_i,
  output logic                push_valid_o,
  output cmd_t                push_cmd_o,
  input  logic                push_ready_i
);

  logic               in_number_q, in_number_d;
  logic               input_ended_q, input_ended_d;
  logic [VALUE_W-1:0] accum_q, accum_d;
  logic               accept;
  hex_t               hex;

  assign char_i.ready = push_ready_i;
  assign accept       = char_i.valid && char_i.ready;
  assign hex          = hex_decode(char_i.char_code);

  always_comb begin
    in_number_d      = in_number_q;
    input_ended_d    = input_ended_q;
    accum_d          = accum_q;
    push_valid_o     = 1'b0;
    push_cmd_o.kind  = CMD_VALUE;
    push_cmd_o.value = accum_q;
    if (accept) begin
      if (req_e'(char_i.req_type) == REQ_PAD) begin
        input_ended_d = 1'b1;
        push_valid_o  = 1'b1;
        if (in_number_q) begin
          in_number_d = 1'b0;
          accum_d     = '0;
        end else begin
          push_cmd_o.kind = CMD_ZERO;
        end
      end else if (!input_ended_q) begin
        if (!in_number_q) begin
          if (char_i.char_code == CH_LOWER_X || char_i.char_code == CH_UPPER_X) begin
            in_number_d = 1'b1;
            accum_d     = '0;
          end
        end else if (hex.is_hex) begin
          // keep only the last four digits
          accum_d = {accum_q[VALUE_W-5:0], hex.nibble};
        end else begin
          // terminator is swallowed
          push_valid_o = 1'b1;
          in_number_d  = 1'b0;
          accum_d      = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_number_q   <= 1'b0;
      input_ended_q <= 1'b0;
      accum_q       <= '0;
    end else begin
      in_number_q   <= in_number_d;
      input_ended_q <= input_ended_d;
      accum_q       <= accum_d;
    end
  end

endmodule

// ===== design/xbm2pbm_queue.sv =====
// ----------------------------------------------------------------------------
// XBM to PBM byte converter: command queue
// Small register FIFO between front end and byte emitter.
// ----------------------------------------------------------------------------
module xbm2pbm_queue
  import xbm2pbm_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  input  cmd_t        push_cmd_i,
  output logic        push_ready_o,
  output queue_head_t head_o,
  input  logic        pop_i
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && (count_q != '0);
  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = entries_q[rd_ptr_q];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== design/xbm2pbm_back.sv =====
// ----------------------------------------------------------------------------
// XBM to PBM byte converter: byte emitter
// Turns queued commands into bit-reversed bytes and tracks row and image ends.
// ----------------------------------------------------------------------------
module xbm2pbm_back
  import xbm2pbm_pkg::*;
#(
  parameter int unsigned DIM_W = FIELD_DIM_W,
  parameter int unsigned COL_W = 9,
  parameter int unsigned ROW_W = FIELD_DIM_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  queue_head_t      head_i,
  output logic             pop_o,
  input  logic [COL_W:0]   bytes_per_row_i,
  input  logic [DIM_W-1:0] rows_i,
  input  logic             short_mode_i,
  output back_stat_t       stat_o,
  xbm2pbm_out_if.source    byte_o
);

  typedef enum logic {
    PH_LOW  = 1'b0,
    PH_HIGH = 1'b1
  } phase_e;

  phase_e           phase_q, phase_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       byte_q, byte_d;
  logic             row_last_q, row_last_d;
  logic             img_last_q, img_last_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             done_q, done_d;

  logic             can_load;
  logic [COL_W:0]   col_next;
  logic [DIM_W:0]   row_next;
  logic             row_end, img_end;
  logic [7:0]       raw_byte;

  assign can_load = !out_valid_q || byte_o.ready;
  assign col_next = {1'b0, col_q} + 1'b1;
  assign row_next = (DIM_W+1)'(row_q) + 1'b1;
  assign row_end  = (col_next >= bytes_per_row_i);
  assign img_end  = row_end && (row_next >= {1'b0, rows_i});

  always_comb begin
    if (phase_q == PH_HIGH) begin
      raw_byte = head_i.cmd.value[15:8];
    end else if (head_i.cmd.kind == CMD_ZERO) begin
      raw_byte = '0;
    end else begin
      raw_byte = head_i.cmd.value[7:0];
    end
  end

  always_comb begin
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    byte_d      = byte_q;
    row_last_d  = row_last_q;
    img_last_d  = img_last_q;
    col_d       = col_q;
    row_d       = row_q;
    done_d      = done_q;
    pop_o       = 1'b0;
    if (out_valid_q && byte_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (head_i.valid) begin
      if (done_q) begin
        // drop anything after the image end
        pop_o = 1'b1;
      end else if (can_load) begin
        out_valid_d = 1'b1;
        byte_d      = flip8(raw_byte);
        row_last_d  = row_end;
        img_last_d  = img_end;
        if (row_end) begin
          col_d = '0;
          if (img_end) begin
            done_d = 1'b1;
            row_d  = '0;
          end else begin
            row_d = row_next[ROW_W-1:0];
          end
        end else begin
          col_d = col_next[COL_W-1:0];
        end
        // high byte follows only if the low byte left the row open
        if (phase_q == PH_LOW && head_i.cmd.kind == CMD_VALUE && short_mode_i && !row_end) begin
          phase_d = PH_HIGH;
        end else begin
          phase_d = PH_LOW;
          pop_o   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LOW;
      out_valid_q <= 1'b0;
      byte_q      <= '0;
      row_last_q  <= 1'b0;
      img_last_q  <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      done_q      <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      byte_q      <= byte_d;
      row_last_q  <= row_last_d;
      img_last_q  <= img_last_d;
      col_q       <= col_d;
      row_q       <= row_d;
      done_q      <= done_d;
    end
  end

  assign byte_o.valid         = out_valid_q;
  assign byte_o.pixel_byte    = byte_q;
  assign byte_o.last_in_row   = row_last_q;
  assign byte_o.last_in_image = img_last_q;

  assign stat_o.image_done   = done_q;
  assign stat_o.high_pending = (phase_q == PH_HIGH);

endmodule

// ===== design/xbm_hex_to_pbm_bytes_top.sv =====
// ----------------------------------------------------------------------------
// XBM to PBM byte converter: top level
// Converts the hex body of an X bitmap into PBM raw bytes, one character a
// word in and one byte a word out. A front end takes one character every cycle
// while the command queue has room, finds 'x' or 'X', gathers hex digits and
// on the first non-hex character (swallowed) queues the value; a pad request
// closes an open value or queues a zero byte, and after it body characters are
// ignored. A four-word command queue parts the front end from the byte emitter,
// which sends the bit-reversed low byte and, in 16-bit mode, the bit-reversed
// high byte unless the low byte closed its row. The emitter sends one byte per
// cycle while the output takes them, so a value costs one or two output bytes
// against at least two input characters; a byte passes a queue entry and the
// output register after the character ending its value is taken. Bytes carry
// row and image end marks; after the image end every word is taken and dropped
// until reset. Zero width or height counts as one; each is capped at MAX_DIM-1
// and at FIELD_DIM_MAX. Write the registers only while the block is idle.
// ----------------------------------------------------------------------------
`include "xbm_hex_to_pbm_bytes_top_assert.svh"

module xbm_hex_to_pbm_bytes_top
  import xbm2pbm_pkg::*;
#(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  xbm2pbm_cfg_if.sink    cfg_i,
  xbm2pbm_in_if.sink     char_i,
  xbm2pbm_out_if.source  byte_o
);

  // Largest usable dimension: the register range, capped by MAX_DIM-1.
  localparam int unsigned LIM   = (MAX_DIM - 1 < FIELD_DIM_MAX) ? MAX_DIM - 1 : FIELD_DIM_MAX;
  localparam int unsigned DIM_W = $clog2(LIM + 1);
  localparam int unsigned COL_W = ($clog2((LIM + 7) / 8) > 0) ? $clog2((LIM + 7) / 8) : 1;
  localparam int unsigned ROW_W = ($clog2(LIM) > 0) ? $clog2(LIM) : 1;

  logic [FIELD_DIM_W-1:0] width_q, height_q;
  logic                   short_q;
  logic [DIM_W-1:0]       eff_width, eff_height;
  logic [DIM_W:0]         width_round;
  logic [COL_W:0]         bytes_per_row;

  logic        push_valid, push_ready, pop;
  cmd_t        push_cmd;
  queue_head_t head;
  back_stat_t  stat;

  // Configuration registers: always ready, unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= FIELD_DIM_W'(1);
      height_q <= FIELD_DIM_W'(1);
      short_q  <= 1'b0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (reg_idx_e'(cfg_i.index))
        REG_IMAGE_WIDTH:  width_q  <= cfg_i.data;
        REG_IMAGE_HEIGHT: height_q <= cfg_i.data;
        REG_SHORT_WORDS:  short_q  <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Clamp dimensions to 1..LIM.
  always_comb begin
    if (width_q == '0) begin
      eff_width = DIM_W'(1);
    end else if (32'(width_q) > LIM) begin
      eff_width = DIM_W'(LIM);
    end else begin
      eff_width = DIM_W'(width_q);
    end
    if (height_q == '0) begin
      eff_height = DIM_W'(1);
    end else if (32'(height_q) > LIM) begin
      eff_height = DIM_W'(LIM);
    end else begin
      eff_height = DIM_W'(height_q);
    end
  end

  // Bytes per row: ceil(width / 8).
  assign width_round   = {1'b0, eff_width} + (DIM_W+1)'(7);
  assign bytes_per_row = (COL_W+1)'(width_round >> 3);

  xbm2pbm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_i       (char_i),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd),
    .push_ready_i (push_ready)
  );

  xbm2pbm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .head_o       (head),
    .pop_i        (pop)
  );

  xbm2pbm_back #(
    .DIM_W (DIM_W),
    .COL_W (COL_W),
    .ROW_W (ROW_W)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .pop_o           (pop),
    .bytes_per_row_i (bytes_per_row),
    .rows_i          (eff_height),
    .short_mode_i    (short_q),
    .stat_o          (stat),
    .byte_o          (byte_o)
  );

  // An image end mark only shows once the emitter has closed the image.
  `XBM2PBM_ASSERT_NOW(a_image_end_done, byte_o.valid && byte_o.last_in_image, stat.image_done, "image end mark without image done")
  // The image end is always a row end.
  `XBM2PBM_ASSERT_NOW(a_image_end_row, byte_o.valid && byte_o.last_in_image, byte_o.last_in_row, "image end mark without row end")
  // Nothing new leaves once the image is done and the output is empty.
  `XBM2PBM_ASSERT_NEXT(a_quiet_after_done, stat.image_done && !byte_o.valid, !byte_o.valid, "byte emitted after image end")
  // A pending high byte goes out right after the low byte is taken.
  `XBM2PBM_ASSERT_NEXT(a_high_follows, stat.high_pending && byte_o.valid && byte_o.ready, byte_o.valid, "high byte did not follow")

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// XBM to PBM byte converter: block-level regression
// Feeds hex-body character streams, pad requests and register writes into the
// converter. A scoreboard predicts every PBM byte with its row and image end
// marks and compares each received word against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import xbm2pbm_pkg::*;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
    logic       img_end;
  } pbm_byte_t;

  // Predicts the byte stream from the character stream and checks results.
  class pbm_row_board;
    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic        short_mode;
    logic        in_value;
    logic        ended;
    logic        done;
    logic [15:0] accum;
    int unsigned col;
    int unsigned row;
    pbm_byte_t   due[$];
    int          mismatches;

    function new();
      width_reg  = 12'd1;
      height_reg = 12'd1;
      short_mode = 1'b0;
      in_value   = 1'b0;
      ended      = 1'b0;
      done       = 1'b0;
      accum      = '0;
      col        = 0;
      row        = 0;
      mismatches = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [11:0] d);
      case (idx)
        REG_IMAGE_WIDTH:  width_reg  = d;
        REG_IMAGE_HEIGHT: height_reg = d;
        REG_SHORT_WORDS:  short_mode = d[0];
        default: ;
      endcase
    endfunction

    // Bit 4 set marks a hex digit, bits 3:0 carry its value.
    function logic [4:0] nibble_of(logic [7:0] c);
      if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) return {1'b1, 4'(c - CH_DIGIT_0)};
      if (c >= CH_UPPER_A && c <= CH_UPPER_F) return {1'b1, 4'(c - CH_UPPER_A + 8'd10)};
      if (c >= CH_LOWER_A && c <= CH_LOWER_F) return {1'b1, 4'(c - CH_LOWER_A + 8'd10)};
      return 5'd0;
    endfunction

    // Queue one mirrored byte; return 1 when it closes its row.
    function bit queue_byte(logic [7:0] xbm);
      int unsigned bpr;
      int unsigned rows;
      pbm_byte_t   b;
      bpr  = ((width_reg == 0 ? 1 : int'(width_reg)) + 7) >> 3;
      rows = (height_reg == 0) ? 1 : int'(height_reg);
      for (int i = 0; i < 8; i++) b.pixel[7-i] = xbm[i];
      b.row_end = (col + 1 >= bpr);
      b.img_end = 1'b0;
      if (b.row_end) begin
        col = 0;
        b.img_end = (row + 1 >= rows);
        if (b.img_end) begin
          done = 1'b1;
          row  = 0;
        end else begin
          row = (row + 1) & 12'hfff;
        end
      end else begin
        col = (col + 1) & 9'h1ff;
      end
      due.push_back(b);
      return b.row_end;
    endfunction

    function void close_value();
      bit closed;
      in_value = 1'b0;
      closed = queue_byte(accum[7:0]);
      // The high byte is dropped when the low byte closed the row.
      if (short_mode && !closed && !done) void'(queue_byte(accum[15:8]));
      accum = '0;
    endfunction

    function void note_word(req_e kind, logic [7:0] c);
      logic [4:0] nib;
      if (done) return;
      if (kind == REQ_PAD) begin
        ended = 1'b1;
        if (in_value) close_value();
        else void'(queue_byte(8'h00));
        return;
      end
      if (ended) return;
      if (!in_value) begin
        if (c == CH_LOWER_X || c == CH_UPPER_X) begin
          in_value = 1'b1;
          accum    = '0;
        end
        return;
      end
      nib = nibble_of(c);
      if (nib[4]) accum = {accum[11:0], nib[3:0]};
      else close_value();
    endfunction

    task flag(string msg);
      mismatches++;
      $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_byte(pbm_byte_t got);
      pbm_byte_t want;
      if (due.size() == 0) begin
        flag($sformatf("byte %02h arrived with nothing due", got.pixel));
        return;
      end
      want = due.pop_front();
      if (got.pixel !== want.pixel)
        flag($sformatf("pixel_byte %02h, want %02h", got.pixel, want.pixel));
      if (got.row_end !== want.row_end)
        flag($sformatf("last_in_row %b, want %b", got.row_end, want.row_end));
      if (got.img_end !== want.img_end)
        flag($sformatf("last_in_image %b, want %b", got.img_end, want.img_end));
    endtask
  endclass

  logic clk;
  logic rst_n;

  xbm2pbm_cfg_if cfg_bus ();
  xbm2pbm_in_if  char_bus ();
  xbm2pbm_out_if byte_bus ();

  xbm_hex_to_pbm_bytes_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_bus),
    .char_i (char_bus),
    .byte_o (byte_bus)
  );

  pbm_row_board board;

  // Percent of cycles in which the sender holds back or the receiver stalls.
  int unsigned char_gap_pct;
  int unsigned byte_stall_pct;

  // Long receiver hold-off: requested by the stimulus, counted by the receiver.
  bit          hold_req;
  int unsigned hold_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receive side: check each accepted word, then pick next cycle's ready.
  initial begin
    pbm_byte_t got;
    byte_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (byte_bus.valid && byte_bus.ready) begin
        got.pixel   = byte_bus.pixel_byte;
        got.row_end = byte_bus.last_in_row;
        got.img_end = byte_bus.last_in_image;
        board.check_byte(got);
      end
      if (hold_req) begin
        hold_left = 80;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        // Hold ready low so the command queue fills and the input stalls.
        hold_left--;
        byte_bus.ready <= 1'b0;
      end else begin
        byte_bus.ready <= ($urandom_range(99) >= byte_stall_pct);
      end
    end
  end

  // Offer one word on the character channel and hold it until taken.
  task automatic send_word(req_e kind, logic [7:0] code);
    while ($urandom_range(99) < char_gap_pct) begin
      char_bus.valid <= 1'b0;
      @(posedge clk);
    end
    char_bus.valid     <= 1'b1;
    char_bus.req_type  <= kind;
    char_bus.char_code <= code;
    @(posedge clk);
    while (!char_bus.ready) @(posedge clk);
    board.note_word(kind, code);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(REQ_CHAR, s[i]);
  endtask

  // Pad requests carry a don't-care character.
  task automatic send_pad();
    send_word(REQ_PAD, 8'($urandom_range(255)));
  endtask

  // Write one register; the predictor takes it at the handshake.
  task automatic write_reg(reg_idx_e idx, int unsigned value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value[FIELD_DIM_W-1:0];
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    board.write_reg(idx, value[FIELD_DIM_W-1:0]);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, wait for every due byte, then give the pipe time to empty.
  task automatic settle(int unsigned extra);
    int unsigned guard;
    guard = 0;
    char_bus.valid <= 1'b0;
    while (board.due.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (extra) @(posedge clk);
  endtask

  // Mostly well-formed hex values with random digits and closers,
  // some empty values and some raw noise.
  task automatic send_random(int unsigned n);
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    logic [7:0]  c;
    string       hexset;
    sent   = 0;
    hexset = "0123456789abcdefABCDEF";
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 90) begin
        if (pick < 80 && $urandom_range(3) == 0) begin
          send_word(REQ_CHAR, CH_DIGIT_0);
          sent++;
        end
        send_word(REQ_CHAR, $urandom_range(1) ? CH_LOWER_X : CH_UPPER_X);
        // Empty values for the broken share; else favor 2 and 4 digits.
        if (pick >= 80) len = 0;
        else if ($urandom_range(1)) len = 2 << $urandom_range(1);
        else len = $urandom_range(1, 6);
        repeat (len) send_word(REQ_CHAR, hexset[$urandom_range(21)]);
        case ($urandom_range(5))
          0: c = ",";
          1: c = "}";
          2: c = " ";
          3: c = 8'h0a;
          4: c = CH_UPPER_X;
          default: begin
            c = 8'($urandom_range(255));
            while (board.nibble_of(c) != 5'd0) c = 8'($urandom_range(255));
          end
        endcase
        send_word(REQ_CHAR, c);
        sent += len + 2;
      end else begin
        repeat ($urandom_range(1, 3)) begin
          send_word(REQ_CHAR, 8'($urandom_range(255)));
          sent++;
        end
      end
    end
  endtask

  task automatic run_phase(int unsigned w, int unsigned h, int unsigned m, int unsigned n);
    settle(12);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_SHORT_WORDS, m);
    send_random(n);
  endtask

  initial begin
    int unsigned guard;
    board              = new();
    hold_req           = 1'b0;
    hold_left          = 0;
    char_gap_pct       = 33;
    byte_stall_pct     = 50;
    rst_n              = 1'b0;
    char_bus.valid     = 1'b0;
    char_bus.req_type  = REQ_CHAR;
    char_bus.char_code = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = REG_IMAGE_WIDTH;
    cfg_bus.data       = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Height at its maximum keeps the image open until the final phase;
    // width zero counts as one pixel, so every low byte closes a row and
    // every high byte is dropped.
    write_reg(REG_IMAGE_HEIGHT, FIELD_DIM_MAX);
    write_reg(REG_IMAGE_WIDTH, 0);
    write_reg(REG_SHORT_WORDS, 1);
    // Upper and lower x and hex digits, all-ones and all-zeros bytes,
    // a long run that keeps only its last four digits, stray characters.
    send_text("0XFFa5,0x00 x123456789}q");

    // Sender idles a third of the time, receiver half.
    run_phase(FIELD_DIM_MAX, FIELD_DIM_MAX, 0, 72);
    run_phase(13, 3000, 1, 72);

    // Swap the idle rates.
    char_gap_pct   = 50;
    byte_stall_pct = 33;
    run_phase(1, FIELD_DIM_MAX, 1, 72);
    run_phase(40, 2048, 0, 72);

    // No idling; one long receiver hold-off while characters keep coming.
    char_gap_pct   = 0;
    byte_stall_pct = 0;
    settle(12);
    write_reg(REG_IMAGE_WIDTH, FIELD_DIM_MAX);
    write_reg(REG_SHORT_WORDS, 1);
    hold_req = 1'b1;
    send_random(72);
    // One byte per row here, so the column count ends at zero.
    run_phase(8, FIELD_DIM_MAX, 0, 72);

    // Closing phase: height zero counts as one, so the next row end is the
    // image end. Pad closes an open value, later body characters are
    // dropped, further pads emit zero bytes until the image is done, and
    // anything after that is dropped too.
    settle(12);
    write_reg(REG_IMAGE_WIDTH, 24);
    write_reg(REG_IMAGE_HEIGHT, 0);
    write_reg(REG_SHORT_WORDS, 1);
    send_text("0x5a");
    send_pad();
    send_text("0x7e,");
    guard = 0;
    while (!board.done && guard < 600) begin
      send_pad();
      guard++;
    end
    send_pad();
    send_text("x1,");

    settle(20);
    if (board.due.size() != 0)
      board.flag($sformatf("%0d bytes never arrived", board.due.size()));
    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/xbm2pbm_pkg.sv
design/xbm2pbm_in_if.sv
design/xbm2pbm_out_if.sv
design/xbm2pbm_cfg_if.sv
design/xbm2pbm_front.sv
design/xbm2pbm_queue.sv
design/xbm2pbm_back.sv
design/xbm_hex_to_pbm_bytes_top.sv
tb/tb_top.sv
